@@ sv/imu_tilt_and_rocking_index_top_macros.svh @@
// Assertion macros for the tilt and rocking index RTL.
`ifndef IMU_TILT_AND_ROCKING_INDEX_TOP_MACROS_SVH
`define IMU_TILT_AND_ROCKING_INDEX_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ITRI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define ITRI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ITRI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ITRI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ sv/itri_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package itri_pkg;

  localparam int CordicIterDef = 16;
  localparam int CordicIterMax = 24;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_SMOOTHING_WEIGHT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GYRO_COUNTS_PER_DPS = 2'd1;
  localparam logic [8:0]  SMOOTH_RST = 9'd38;
  localparam logic [15:0] CPD_RST    = 16'd131;

  // Angle selection for the shared CORDIC
  localparam logic [1:0] ANG_PITCH = 2'd0;
  localparam logic [1:0] ANG_ROLL  = 2'd1;
  localparam logic [1:0] ANG_PLANE = 2'd2;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_t;

  typedef struct packed {
    logic signed [14:0] pitch_centideg;
    logic signed [15:0] roll_centideg;
    logic [15:0]        plane_angle_centideg;
    logic [23:0]        rocking_index;
  } out_t;

  typedef struct packed {
    logic       cap;
    logic       sq_step;
    logic [2:0] sq_idx;
    logic       sqrt_start;
    logic       cordic_start;
    logic       ang_store;
    logic [1:0] ang_sel;
    logic       div_start;
    logic       avg_step;
    logic       avg_idx;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic cordic_busy;
    logic div_busy;
  } sts_t;

  // atan(2^-i) in degrees times 65536
  function automatic logic [21:0] atan_q16(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ sv/itri_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module itri_isqrt #(
  parameter int K = 24
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [2*K-1:0] rad_i,
  output logic                busy_o,
  output logic [K-1:0]        root_o
);

  localparam int CntW = $clog2(K + 1);

  logic [2*K-1:0] rad_q;
  logic [K+1:0]   rem_q, rem_sh, trial;
  logic [K-1:0]   root_q;
  logic [CntW-1:0] cnt_q;
  logic           busy_q;

  // Bring down two radicand bits, try the next root bit
  assign rem_sh = {rem_q[K-1:0], rad_q[2*K-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(K - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[K-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[K-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

@@ sv/itri_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
module itri_cordic import itri_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CordicIterDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [27:0] y_i,
  input  wire logic signed [27:0] x_i,
  output logic                    busy_o,
  output logic signed [25:0]      acc_o
);

  localparam int NumIter = (CORDIC_ITERATIONS > CordicIterMax) ? CordicIterMax
                                                               : CORDIC_ITERATIONS;
  localparam int CntW = $clog2(NumIter + 1);
  localparam int W = 44;
  localparam logic signed [25:0] Acc90  = 26'sd5898240;
  localparam logic signed [25:0] Acc180 = 26'sd11796480;

  logic signed [W-1:0] x_q, y_q, xs, ys, dx, dy;
  logic signed [25:0]  acc_q, step_ang;
  logic [CntW-1:0]     i_q;
  logic                busy_q;

  // Scale operands by 4096
  assign xs = {{(W-40){x_i[27]}}, x_i, 12'b0};
  assign ys = {{(W-40){y_i[27]}}, y_i, 12'b0};
  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;
  assign step_ang = 26'(atan_q16(5'(i_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      busy_q <= (y_i != '0);
      i_q    <= '0;
    end else if (busy_q) begin
      if (i_q == CntW'(NumIter) || y_q == '0) busy_q <= 1'b0;
      else i_q <= i_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (y_i == '0) begin
        acc_q <= x_i[27] ? Acc180 : '0;
      end else if (x_i[27] && !y_i[27]) begin
        x_q <= ys; y_q <= -xs; acc_q <= Acc90;
      end else if (x_i[27]) begin
        x_q <= -ys; y_q <= xs; acc_q <= -Acc90;
      end else begin
        x_q <= xs; y_q <= ys; acc_q <= '0;
      end
    end else if (busy_q && i_q != CntW'(NumIter) && y_q != '0) begin
      // Rotate toward the x axis
      if (!y_q[W-1]) begin
        x_q <= x_q + dx; y_q <= y_q - dy; acc_q <= acc_q + step_ang;
      end else begin
        x_q <= x_q - dx; y_q <= y_q + dy; acc_q <= acc_q - step_ang;
      end
    end
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

@@ sv/itri_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module itri_dp import itri_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CordicIterDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire in_t                 in_data_i,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  output out_t                     out_data_o
);

  logic [8:0]  weight_q;
  logic [15:0] cpd_q;
  in_t         in_q;
  logic signed [15:0] mul_op;
  logic [30:0] prod_q;
  logic [31:0] sqa_q, sqg_q;
  logic        pr_busy, gr_busy;
  logic [25:0] pitch_root;
  logic [23:0] gyro_root;
  logic signed [27:0] cy, cx;
  logic        cor_busy;
  logic signed [25:0] cor_acc;
  logic [25:0] acc_mag;
  logic [31:0] cen_prod;
  logic signed [17:0] cen, plane_w;
  logic signed [14:0] pitch_q;
  logic signed [15:0] roll_q;
  logic [15:0] plane_q;
  logic        div_busy_q;
  logic [4:0]  div_cnt_q;
  logic [23:0] dq_q;
  logic [16:0] dr_q, dr_sh;
  logic [15:0] divisor;
  logic [8:0]  w_eff;
  logic [23:0] avg_q;
  logic [32:0] p_q, p_rnd;
  out_t        out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= SMOOTH_RST;
      cpd_q    <= CPD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SMOOTHING_WEIGHT:    weight_q <= cfg_wdata_i[8:0];
        REG_GYRO_COUNTS_PER_DPS: cpd_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sample capture and sum of squares, one product a cycle
  always_comb begin
    case (cmd_i.sq_idx)
      3'd0:    mul_op = in_q.accel_y;
      3'd1:    mul_op = in_q.accel_z;
      3'd2:    mul_op = in_q.gyro_x;
      3'd3:    mul_op = in_q.gyro_y;
      default: mul_op = in_q.gyro_z;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      in_q  <= in_data_i;
      sqa_q <= '0;
      sqg_q <= '0;
    end else if (cmd_i.sq_step) begin
      prod_q <= 31'(mul_op * mul_op);
      if (cmd_i.sq_idx == 3'd1 || cmd_i.sq_idx == 3'd2)
        sqa_q <= sqa_q + 32'(prod_q);
      else if (cmd_i.sq_idx != 3'd0)
        sqg_q <= sqg_q + 32'(prod_q);
    end
  end

  itri_isqrt #(.K(26)) u_pitch_root (
    .clk_i, .rst_ni,
    .start_i (cmd_i.sqrt_start),
    .rad_i   ({sqa_q, 20'b0}),
    .busy_o  (pr_busy),
    .root_o  (pitch_root)
  );

  itri_isqrt #(.K(24)) u_gyro_root (
    .clk_i, .rst_ni,
    .start_i (cmd_i.sqrt_start),
    .rad_i   ({sqg_q, 16'b0}),
    .busy_o  (gr_busy),
    .root_o  (gyro_root)
  );

  // Operand select for the shared CORDIC
  always_comb begin
    case (cmd_i.ang_sel)
      ANG_PITCH: begin
        cy = -({{12{in_q.accel_x[15]}}, in_q.accel_x} <<< 10);
        cx = {2'b0, pitch_root};
      end
      ANG_ROLL: begin
        cy = {{12{in_q.accel_y[15]}}, in_q.accel_y} <<< 10;
        cx = {{12{in_q.accel_z[15]}}, in_q.accel_z} <<< 10;
      end
      default: begin
        cy = {{12{in_q.accel_y[15]}}, in_q.accel_y} <<< 10;
        cx = {{12{in_q.accel_x[15]}}, in_q.accel_x} <<< 10;
      end
    endcase
  end

  itri_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk_i, .rst_ni,
    .start_i (cmd_i.cordic_start),
    .y_i     (cy),
    .x_i     (cx),
    .busy_o  (cor_busy),
    .acc_o   (cor_acc)
  );

  // Degrees Q16 to hundredths, truncated toward zero
  assign acc_mag  = cor_acc[25] ? 26'(-cor_acc) : 26'(cor_acc);
  assign cen_prod = {acc_mag, 6'b0} + {1'b0, acc_mag, 5'b0} + {4'b0, acc_mag, 2'b0};
  assign cen      = cor_acc[25] ? -$signed({2'b0, cen_prod[31:16]})
                                : $signed({2'b0, cen_prod[31:16]});
  assign plane_w  = cen[17] ? cen + 18'sd36000 : cen;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ang_store) begin
      case (cmd_i.ang_sel)
        ANG_PITCH: begin
          if (cen > 18'sd9000)       pitch_q <= 15'sd9000;
          else if (cen < -18'sd9000) pitch_q <= -15'sd9000;
          else                       pitch_q <= 15'(cen);
        end
        ANG_ROLL: begin
          if (cen > 18'sd18000)       roll_q <= 16'sd18000;
          else if (cen < -18'sd18000) roll_q <= -16'sd18000;
          else                        roll_q <= 16'(cen);
        end
        default: begin
          if (plane_w > 18'sd35999) plane_q <= 16'd35999;
          else if (plane_w[17])     plane_q <= '0;
          else                      plane_q <= 16'(plane_w);
        end
      endcase
    end
  end

  // Restoring divider: gyro root over sensitivity, one quotient bit a cycle
  assign divisor = (cpd_q == '0) ? 16'd1 : cpd_q;
  assign dr_sh   = {dr_q[15:0], dq_q[23]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + 1'b1;
      if (div_cnt_q == 5'd23) div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q <= gyro_root;
      dr_q <= '0;
    end else if (div_busy_q) begin
      if (dr_sh >= {1'b0, divisor}) begin
        dr_q <= dr_sh - {1'b0, divisor};
        dq_q <= {dq_q[22:0], 1'b1};
      end else begin
        dr_q <= dr_sh;
        dq_q <= {dq_q[22:0], 1'b0};
      end
    end
  end

  // Exponential average, one weighted product a cycle
  assign w_eff = weight_q[8] ? 9'd256 : weight_q;
  assign p_rnd = p_q + 33'd128;

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_step) begin
      if (!cmd_i.avg_idx) p_q <= 33'(avg_q * (9'd256 - w_eff));
      else                p_q <= p_q + 33'(dq_q * w_eff);
    end
  end

  // Rocking average state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (cmd_i.load_out) begin
      avg_q <= (p_rnd[32:8] > 25'd16777215) ? 24'hFFFFFF : p_rnd[31:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.pitch_centideg       <= pitch_q;
      out_q.roll_centideg        <= roll_q;
      out_q.plane_angle_centideg <= plane_q;
      out_q.rocking_index        <= (p_rnd[32:8] > 25'd16777215) ? 24'hFFFFFF
                                                                 : p_rnd[31:8];
    end
  end

  assign sts_o.sqrt_busy   = pr_busy | gr_busy;
  assign sts_o.cordic_busy = cor_busy;
  assign sts_o.div_busy    = div_busy_q;
  assign out_data_o        = out_q;

endmodule
`default_nettype wire

@@ sv/itri_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "imu_tilt_and_rocking_index_top_macros.svh"
module itri_ctrl import itri_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_ROOT = 7'b0000100,
    S_ANG  = 7'b0001000,
    S_DIVW = 7'b0010000,
    S_AVG  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] sel_q, sel_d;
  logic       out_valid_q, out_free;
  logic       restart;
  logic       launch_q;

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequence one sample through the datapath
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.sq_idx  = cnt_q;
    cmd_o.ang_sel = sel_q;
    cmd_o.avg_idx = cnt_q[0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          cnt_d     = '0;
          state_d   = S_SQ;
        end
      end
      S_SQ: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'd6) begin
          cmd_o.sqrt_start = 1'b1;
          state_d = S_ROOT;
        end else begin
          cmd_o.sq_step = 1'b1;
        end
      end
      S_ROOT: begin
        if (!sts_i.sqrt_busy) begin
          cmd_o.ang_sel      = ANG_PITCH;
          cmd_o.cordic_start = 1'b1;
          cmd_o.div_start    = 1'b1;
          sel_d   = ANG_PITCH;
          state_d = S_ANG;
        end
      end
      S_ANG: begin
        if (launch_q) begin
          cmd_o.cordic_start = 1'b1;
        end else if (!sts_i.cordic_busy) begin
          cmd_o.ang_store = 1'b1;
          if (sel_q == ANG_PLANE) begin
            state_d = S_DIVW;
          end else begin
            sel_d = sel_q + 1'b1;
            state_d = S_ANG;
          end
        end
      end
      S_DIVW: begin
        if (!sts_i.div_busy) begin
          cnt_d   = '0;
          state_d = S_AVG;
        end
      end
      S_AVG: begin
        cmd_o.avg_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[0]) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Start the next angle right after the previous one is stored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sel_q       <= ANG_PITCH;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      if (cmd_o.load_out)   out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign restart = (state_q == S_ANG) && !launch_q && !sts_i.cordic_busy &&
                   (sel_q != ANG_PLANE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Launch the following angle on the cycle after a store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) launch_q <= 1'b0;
    else         launch_q <= restart;
  end

  `ITRI_ASSERT_IMP(a_load_free, clk_i, rst_ni, cmd_o.load_out, out_free, "load over beat")
  `ITRI_ASSERT_NXT(a_load_valid, clk_i, rst_ni, cmd_o.load_out, out_valid_q, "beat lost")
  `ITRI_ASSERT_NXT(a_div_runs, clk_i, rst_ni, cmd_o.div_start, sts_i.div_busy, "div idle")
  `ITRI_ASSERT_IMP(a_cor_free, clk_i, rst_ni, cmd_o.cordic_start, !sts_i.cordic_busy, "cordic busy")

endmodule
`default_nettype wire

@@ sv/imu_tilt_and_rocking_index_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// IMU tilt angles and rocking index.
// Input channel: in_valid_i / in_stall_o carry one six-axis sample per beat;
// a beat is taken while the block is idle. Output channel: out_valid_o /
// out_stall_i carry pitch, roll, plane angle (hundredths of a degree) and the
// rocking index (gyro magnitude average, dps times 256).
// Each sample runs in order through the squares and the two serial roots,
// then three CORDIC passes on one shared unit (the gyro division runs beside
// them), then the average and the output load. One sample is in flight at a
// time, so a new beat can be taken in the cycle after the previous result is
// loaded.
// A finished beat sits in the output register; the next sample may be taken
// meanwhile and waits for that register before it is loaded.
// Reset clears the average to zero and sets smoothing_weight to 38 and
// gyro_counts_per_dps to 131. The user writes configuration by cfg_we_i with
// cfg_index_i and cfg_wdata_i only while idle; the block does not enforce it.
module imu_tilt_and_rocking_index_top import itri_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CordicIterDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_t                 in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_t                     out_data_o
);

  cmd_t cmd;
  sts_t sts;

  itri_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .out_valid_o, .out_stall_i,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  itri_dp #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_data_i,
    .cmd_i (cmd),
    .sts_o (sts),
    .out_data_o
  );

endmodule
`default_nettype wire
